@@ rtl/core/bnhc_pkg.sv @@
// Package for the nearest-barcode classifier: field widths, codes, FSM states
// and the control structs shared by the core modules. No dependencies.
`default_nettype none

package bnhc_pkg;

    localparam int DICT_DEPTH_DEFAULT = 256;
    localparam int MAX_CHARS_DEFAULT  = 8;

    localparam int BARCODE_W = 64;
    localparam int INDEX_W   = 8;
    localparam int COUNT_W   = 9;
    localparam int DIST_W    = 4;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISMATCH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BARCODE_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT    = 2'd2;

    localparam logic [CFG_W-1:0]   MAX_MISMATCH_RESET   = 4'd1;
    localparam logic [CFG_W-1:0]   BARCODE_LENGTH_RESET = 4'd6;
    localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET    = 9'd0;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_MATCH     = 2'd0,
        VERDICT_AMBIGUOUS = 2'd1,
        VERDICT_NONE      = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic clear;
        logic rd_en;
    } scan_ctl_t;

    typedef struct packed {
        logic rd_valid;
        logic dist_valid;
    } pipe_status_t;

endpackage

`default_nettype wire

@@ rtl/core/bnhc_dict.sv @@
// Dictionary memory of the classifier: one write port for load requests and
// one registered read port for the scan. Uses bnhc_pkg.
`default_nettype none

module bnhc_dict #(
    parameter int DICT_DEPTH = bnhc_pkg::DICT_DEPTH_DEFAULT,
    parameter int MAX_CHARS  = bnhc_pkg::MAX_CHARS_DEFAULT,
    parameter int AW = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  logic [8*MAX_CHARS-1:0] wr_data,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    output logic [8*MAX_CHARS-1:0] rd_data,
    output logic [AW-1:0]          rd_idx,
    output logic                   rd_valid
);
    import bnhc_pkg::*;

    logic [8*MAX_CHARS-1:0] mem [DICT_DEPTH];
    logic [8*MAX_CHARS-1:0] rd_data_reg;
    logic [AW-1:0]          rd_idx_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_en;
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_idx   = rd_idx_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

@@ rtl/core/bnhc_match.sv @@
// Shared distance and compare unit: counts unequal characters of one entry
// per cycle and keeps the running minimum and tie state. Uses bnhc_pkg.
`default_nettype none

module bnhc_match #(
    parameter int MAX_CHARS = bnhc_pkg::MAX_CHARS_DEFAULT,
    parameter int AW = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bnhc_pkg::scan_ctl_t       scan_ctl,
    input  logic [8*MAX_CHARS-1:0]    code_in,
    input  logic [bnhc_pkg::CFG_W-1:0] len_eff,
    input  logic [bnhc_pkg::CFG_W-1:0] cutoff,
    input  logic                      rd_valid,
    input  logic [8*MAX_CHARS-1:0]    rd_data,
    input  logic [AW-1:0]             rd_idx,
    output logic                      dist_valid,
    output logic                      hit,
    output logic                      multi,
    output logic [bnhc_pkg::DIST_W-1:0] best,
    output logic [AW-1:0]             best_idx
);
    import bnhc_pkg::*;

    logic [8*MAX_CHARS-1:0] code_reg;
    logic [DIST_W-1:0]      dist_next;
    logic [DIST_W-1:0]      dist_reg;
    logic [AW-1:0]          idx_reg;
    logic                   dist_valid_reg;
    logic                   hit_reg;
    logic                   multi_reg;
    logic [DIST_W-1:0]      best_reg;
    logic [AW-1:0]          best_idx_reg;

    always_comb begin
        dist_next = '0;
        for (int i = 0; i < MAX_CHARS; i++) begin
            if ((CFG_W'(i) < len_eff) && (rd_data[8*i +: 8] != code_reg[8*i +: 8])) begin
                dist_next = dist_next + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_ctl.clear) begin
            code_reg <= code_in;
        end
        if (rd_valid) begin
            dist_reg <= dist_next;
            idx_reg  <= rd_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_valid_reg <= 1'b0;
            hit_reg        <= 1'b0;
            multi_reg      <= 1'b0;
            best_reg       <= '0;
            best_idx_reg   <= '0;
        end else begin
            dist_valid_reg <= rd_valid;
            if (scan_ctl.clear) begin
                hit_reg      <= 1'b0;
                multi_reg    <= 1'b0;
                best_reg     <= cutoff + 1'b1;
                best_idx_reg <= '0;
            end else if (dist_valid_reg && (dist_reg <= cutoff)) begin
                if (dist_reg < best_reg) begin
                    hit_reg      <= 1'b1;
                    multi_reg    <= 1'b0;
                    best_reg     <= dist_reg;
                    best_idx_reg <= idx_reg;
                end else if (dist_reg == best_reg) begin
                    multi_reg <= 1'b1;
                end
            end
        end
    end

    assign dist_valid = dist_valid_reg;
    assign hit        = hit_reg;
    assign multi      = multi_reg;
    assign best       = best_reg;
    assign best_idx   = best_idx_reg;

endmodule

`default_nettype wire

@@ rtl/core/bnhc_ctrl.sv @@
// Sequencer of the classifier: accepts requests, walks the dictionary
// addresses and hands the result to the output register. Uses bnhc_pkg.
`default_nettype none

module bnhc_ctrl #(
    parameter int DICT_DEPTH = bnhc_pkg::DICT_DEPTH_DEFAULT,
    parameter int AW = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_op,
    input  logic [bnhc_pkg::COUNT_W-1:0] entry_count,
    input  bnhc_pkg::pipe_status_t      pipe_status,
    input  logic                        out_free,
    output logic                        s_ready,
    output bnhc_pkg::scan_ctl_t         scan_ctl,
    output logic [AW-1:0]               rd_addr,
    output logic                        out_load
);
    import bnhc_pkg::*;

    localparam int DW = $clog2(DICT_DEPTH + 1);
    localparam int LW = (DW > COUNT_W) ? DW : COUNT_W;
    localparam int PW = (LW > AW) ? LW : AW;

    ctrl_state_t   state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] count_wide;
    logic [LW-1:0] count_clip;
    logic [PW-1:0] cnt_wide;
    logic [PW-1:0] last_wide;
    logic          count_zero;
    logic          cnt_last;
    logic          start;
    logic          pipe_empty;

    assign count_wide = LW'(entry_count);
    assign count_clip = (count_wide > LW'(DICT_DEPTH)) ? LW'(DICT_DEPTH) : count_wide;
    assign count_zero = (count_clip == '0);
    assign cnt_wide   = PW'(cnt_reg);
    assign last_wide  = PW'(count_clip - 1'b1);
    assign cnt_last   = (cnt_wide == last_wide);
    assign start      = (state_reg == ST_IDLE) && s_valid && (s_op == OP_CLASSIFY);
    assign pipe_empty = !pipe_status.rd_valid && !pipe_status.dist_valid;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (start) begin
                    state_next = count_zero ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (pipe_empty) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        scan_ctl.clear = 1'b0;
        scan_ctl.rd_en = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready        = 1'b1;
                scan_ctl.clear = start;
            end
            ST_SCAN: begin
                scan_ctl.rd_en = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_DONE: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign rd_addr = cnt_reg;

endmodule

`default_nettype wire

@@ rtl/core/barcode_nearest_hamming_classifier.sv @@
// Top level of the nearest-barcode classifier: configuration registers,
// output register and the sequencer, dictionary and compare unit below it.
// A load request writes one dictionary slot when its index is below
// DICT_DEPTH. A classify request scans min(entry_count, DICT_DEPTH) entries
// and the block is ready again once its result is handed to the output
// register, which waits until it is free: the single read port of the
// dictionary delivers one entry per cycle to the shared distance and compare
// unit, followed by a drain of the read and compare stages and the hand-over
// of the result. The block takes no request while a
// classification runs; a finished result waits in the output register while
// the next request is already taken. The dictionary has no reset, so every
// slot below entry_count must be loaded before it is classified against.
`default_nettype none

module barcode_nearest_hamming_classifier #(
    parameter int DICT_DEPTH = bnhc_pkg::DICT_DEPTH_DEFAULT,
    parameter int MAX_CHARS  = bnhc_pkg::MAX_CHARS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_op,
    input  logic [bnhc_pkg::INDEX_W-1:0]     s_entry_index,
    input  logic [bnhc_pkg::BARCODE_W-1:0]   s_barcode,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_verdict,
    output logic [bnhc_pkg::INDEX_W-1:0]     m_match_index,
    output logic [bnhc_pkg::DIST_W-1:0]      m_min_distance,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bnhc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bnhc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bnhc_pkg::*;

    localparam int AW  = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
    localparam int CW  = 8 * MAX_CHARS;

    logic [CFG_W-1:0]   max_mismatch_reg;
    logic [CFG_W-1:0]   barcode_length_reg;
    logic [COUNT_W-1:0] entry_count_reg;
    logic [CFG_W-1:0]   len_eff;
    logic [CFG_W-1:0]   cutoff;

    logic               m_valid_reg;
    verdict_t           verdict_reg;
    logic [INDEX_W-1:0] match_index_reg;
    logic [DIST_W-1:0]  min_distance_reg;

    scan_ctl_t          scan_ctl;
    pipe_status_t       pipe_status;
    logic               rd_valid;
    logic               dist_valid;
    logic [AW-1:0]      rd_addr;
    logic [CW-1:0]      rd_data;
    logic [AW-1:0]      rd_idx;
    logic               out_load;
    logic               out_free;
    logic               wr_en;
    logic [AW+INDEX_W-1:0] wr_addr_wide;
    logic [AW+INDEX_W-1:0] best_idx_wide;
    logic               hit;
    logic               multi;
    logic [DIST_W-1:0]  best;
    logic [AW-1:0]      best_idx;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_mismatch_reg   <= MAX_MISMATCH_RESET;
            barcode_length_reg <= BARCODE_LENGTH_RESET;
            entry_count_reg    <= ENTRY_COUNT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MAX_MISMATCH:   max_mismatch_reg   <= cfg_data[CFG_W-1:0];
                CFG_BARCODE_LENGTH: barcode_length_reg <= cfg_data[CFG_W-1:0];
                CFG_ENTRY_COUNT:    entry_count_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (barcode_length_reg == '0) begin
            len_eff = CFG_W'(1);
        end else if (barcode_length_reg > CFG_W'(MAX_CHARS)) begin
            len_eff = CFG_W'(MAX_CHARS);
        end else begin
            len_eff = barcode_length_reg;
        end
        if (max_mismatch_reg > CFG_W'(MAX_CHARS)) begin
            cutoff = CFG_W'(MAX_CHARS);
        end else begin
            cutoff = max_mismatch_reg;
        end
    end

    assign wr_addr_wide = (AW + INDEX_W)'(s_entry_index);
    assign wr_en = s_valid && s_ready && (s_op == OP_LOAD)
                   && (int'(s_entry_index) < DICT_DEPTH);

    assign pipe_status = '{rd_valid: rd_valid, dist_valid: dist_valid};

    bnhc_ctrl #(
        .DICT_DEPTH(DICT_DEPTH),
        .AW(AW)
    ) u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_op(s_op),
        .entry_count(entry_count_reg),
        .pipe_status(pipe_status),
        .out_free(out_free),
        .s_ready(s_ready),
        .scan_ctl(scan_ctl),
        .rd_addr(rd_addr),
        .out_load(out_load)
    );

    bnhc_dict #(
        .DICT_DEPTH(DICT_DEPTH),
        .MAX_CHARS(MAX_CHARS),
        .AW(AW)
    ) u_dict (
        .aclk(aclk),
        .aresetn(aresetn),
        .wr_en(wr_en),
        .wr_addr(wr_addr_wide[AW-1:0]),
        .wr_data(s_barcode[CW-1:0]),
        .rd_en(scan_ctl.rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .rd_idx(rd_idx),
        .rd_valid(rd_valid)
    );

    bnhc_match #(
        .MAX_CHARS(MAX_CHARS),
        .AW(AW)
    ) u_match (
        .aclk(aclk),
        .aresetn(aresetn),
        .scan_ctl(scan_ctl),
        .code_in(s_barcode[CW-1:0]),
        .len_eff(len_eff),
        .cutoff(cutoff),
        .rd_valid(rd_valid),
        .rd_data(rd_data),
        .rd_idx(rd_idx),
        .dist_valid(dist_valid),
        .hit(hit),
        .multi(multi),
        .best(best),
        .best_idx(best_idx)
    );

    assign out_free      = !m_valid_reg || m_ready;
    assign best_idx_wide = (AW + INDEX_W)'(best_idx);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            min_distance_reg <= best;
            if (!hit) begin
                verdict_reg     <= VERDICT_NONE;
                match_index_reg <= '0;
            end else if (multi) begin
                verdict_reg     <= VERDICT_AMBIGUOUS;
                match_index_reg <= '0;
            end else begin
                verdict_reg     <= VERDICT_MATCH;
                match_index_reg <= best_idx_wide[INDEX_W-1:0];
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_verdict      = verdict_reg;
    assign m_match_index  = match_index_reg;
    assign m_min_distance = min_distance_reg;

endmodule

`default_nettype wire
